// File: rtl/cmie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmie_pkg
// Shared types, codes and helpers of the card machine instruction executor.
// ----------------------------------------------------------------------------
package cmie_pkg;

   // field widths
   localparam int WORD_W = 32;
   localparam int KIND_W = 3;
   localparam int REQ_W  = 3;
   localparam int ADDR_W = 7;
   localparam int CNT_W  = 4;
   localparam int MASK_W = 4;

   // default sizes
   localparam int MEM_WORDS_DEF   = 100;
   localparam int BLOCK_WORDS_DEF = 10;

   // request codes
   localparam logic [REQ_W-1:0] REQ_JOB   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PROG  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_BEGIN = 3'd2;
   localparam logic [REQ_W-1:0] REQ_STEP  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_DATA  = 3'd4;

   // result codes
   localparam logic [KIND_W-1:0] KIND_ACK   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PRINT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WAIT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_HALT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ERR   = 3'd4;

   // characters
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_L     = 8'h4C;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [WORD_W-1:0] SPACES = {4{CH_SPACE}};

   // access to the word store
   typedef struct packed {
      logic              clear;
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [WORD_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } store_req_type;

   // one bit per non-space character, bit 3 for the first character
   function automatic logic [MASK_W-1:0] keep_mask_of(input logic [WORD_W-1:0] w);
      logic [MASK_W-1:0] m;
      m = '0;
      for (int i = 0; i < MASK_W; i++) begin
         m[i] = (w[8*i +: 8] != CH_SPACE);
      end
      return m;
   endfunction

   // character is a decimal digit
   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage
`default_nettype wire

// File: rtl/cmie_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmie_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cmie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 100
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: rtl/cmie_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmie_store
// Word store: RAM plus per-word valid bits; words never written read as spaces.
// ----------------------------------------------------------------------------
module cmie_store #(
   parameter int MEM_WORDS = cmie_pkg::MEM_WORDS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cmie_pkg::store_req_type      req,
   output      logic [cmie_pkg::WORD_W-1:0]  rdata
);
   import cmie_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);

   logic [MEM_WORDS-1:0] valid_ff;
   logic [MEM_WORDS-1:0] valid_in;
   logic                 rd_valid_ff;
   logic                 rd_valid_in;
   logic [WORD_W-1:0]    ram_q;

   cmie_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (req.we),
      .waddr (req.waddr[AW-1:0]),
      .wdata (req.wdata),
      .re    (req.re),
      .raddr (req.raddr[AW-1:0]),
      .rdata (ram_q)
   );

   // valid bits: cleared by job start, set on write
   always_comb begin
      valid_in = valid_ff;
      if (req.clear) begin
         valid_in = '0;
      end else if (req.we) begin
         valid_in[req.waddr[AW-1:0]] = 1'b1;
      end
      rd_valid_in = rd_valid_ff;
      if (req.re) begin
         rd_valid_in = valid_ff[req.raddr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign rdata = rd_valid_ff ? ram_q : SPACES;

endmodule
`default_nettype wire

// File: rtl/card_machine_instruction_executor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// card_machine_instruction_executor_unit
// Card-driven machine: loads program words, runs LR/SR/CR/BT/GD/PD/H steps.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one word per request (job start, program word,
//   begin execute, step, data word). The rsp_ channel returns one result
//   word per request, except a PD step, which returns BLOCK_WORDS print
//   words, the last one flagged by rsp_last_of_run.
//   A word is taken at a rising edge with valid high and stall low.
//   Program word, begin, data and job start requests, and a step answered
//   without a fetch (halted, awaiting data, counter overflow), pass from
//   idle to the result state; a step that fetches passes through the fetch
//   state, and LR and CR also through the load or compare state (extra
//   store read). A PD step passes from fetch to the print state and emits
//   one print word per cycle while the result register is free. One
//   request is in flight at a time: req_stall stays high until idle again.
//   The result register lets a new request be taken while the last result
//   is still stalled; any further result waits until the register frees.
//   Reset (synchronous) and job start both mark every store word as spaces
//   through per-word valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module card_machine_instruction_executor_unit #(
   parameter int MEM_WORDS   = cmie_pkg::MEM_WORDS_DEF,
   parameter int BLOCK_WORDS = cmie_pkg::BLOCK_WORDS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic [cmie_pkg::REQ_W-1:0]   req_type,
   input  wire logic [cmie_pkg::WORD_W-1:0]  req_card_word,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [cmie_pkg::KIND_W-1:0]  rsp_result_kind,
   output      logic [cmie_pkg::WORD_W-1:0]  rsp_print_word,
   output      logic [cmie_pkg::MASK_W-1:0]  rsp_keep_mask,
   output      logic                         rsp_last_of_run,
   output      logic [cmie_pkg::ADDR_W-1:0]  rsp_counter_value,
   output      logic                         rsp_compare_flag
);
   import cmie_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FETCH  = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_CMP    = 3'd3;
   localparam logic [2:0] ST_PRINT  = 3'd4;
   localparam logic [2:0] ST_RESULT = 3'd5;

   localparam logic [ADDR_W-1:0] MEM_LIMIT = ADDR_W'(MEM_WORDS);
   localparam logic [CNT_W-1:0]  BLK_CNT   = CNT_W'(BLOCK_WORDS);
   localparam logic [CNT_W-1:0]  BLK_LAST  = CNT_W'(BLOCK_WORDS - 1);

   // machine state
   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] ic_ff, ic_in;
   logic [WORD_W-1:0] greg_ff, greg_in;
   logic              toggle_ff, toggle_in;
   logic [ADDR_W-1:0] lp_ff, lp_in;
   logic              pending_ff, pending_in;
   logic [ADDR_W-1:0] dptr_ff, dptr_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic              halted_ff, halted_in;
   logic [ADDR_W-1:0] pptr_ff, pptr_in;
   logic [CNT_W-1:0]  pcnt_ff, pcnt_in;
   logic [KIND_W-1:0] kind_ff, kind_in;

   // result register
   logic              rv_ff, rv_in;
   logic [KIND_W-1:0] rkind_ff, rkind_in;
   logic [WORD_W-1:0] rword_ff, rword_in;
   logic [MASK_W-1:0] rmask_ff, rmask_in;
   logic              rlast_ff, rlast_in;
   logic [ADDR_W-1:0] rcnt_ff, rcnt_in;
   logic              rflag_ff, rflag_in;

   store_req_type     st_req;
   logic [WORD_W-1:0] st_rdata;

   logic              accept;
   logic              out_free;
   logic [7:0]        c0, c1, c2, c3;
   logic [ADDR_W-1:0] opnd;
   logic              opnd_ok;
   logic              blk_ok;

   cmie_store #(
      .MEM_WORDS (MEM_WORDS)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .req   (st_req),
      .rdata (st_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rv_ff || !rsp_stall;

   // operand decode of the fetched instruction
   always_comb begin
      c0      = st_rdata[31:24];
      c1      = st_rdata[23:16];
      c2      = st_rdata[15:8];
      c3      = st_rdata[7:0];
      opnd    = ({3'b000, c2[3:0]} << 3) + ({3'b000, c2[3:0]} << 1) + {3'b000, c3[3:0]};
      opnd_ok = is_digit(c2) && is_digit(c3) && (opnd < MEM_LIMIT);
      blk_ok  = ({1'b0, opnd} + 8'(BLOCK_WORDS)) <= 8'(MEM_WORDS);
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      ic_in      = ic_ff;
      greg_in    = greg_ff;
      toggle_in  = toggle_ff;
      lp_in      = lp_ff;
      pending_in = pending_ff;
      dptr_in    = dptr_ff;
      rem_in     = rem_ff;
      halted_in  = halted_ff;
      pptr_in    = pptr_ff;
      pcnt_in    = pcnt_ff;
      kind_in    = kind_ff;
      st_req     = '0;

      rv_in    = rv_ff && rsp_stall;
      rkind_in = rkind_ff;
      rword_in = rword_ff;
      rmask_in = rmask_ff;
      rlast_in = rlast_ff;
      rcnt_in  = rcnt_ff;
      rflag_in = rflag_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RESULT;
               kind_in  = KIND_ACK;
               unique case (req_type)
                  REQ_JOB: begin
                     st_req.clear = 1'b1;
                     ic_in        = '0;
                     greg_in      = SPACES;
                     toggle_in    = 1'b0;
                     lp_in        = '0;
                     pending_in   = 1'b0;
                     dptr_in      = '0;
                     rem_in       = '0;
                     halted_in    = 1'b0;
                  end
                  REQ_PROG: begin
                     if (lp_ff < MEM_LIMIT) begin
                        st_req.we    = 1'b1;
                        st_req.waddr = lp_ff;
                        st_req.wdata = req_card_word;
                        lp_in        = lp_ff + 1'b1;
                     end
                  end
                  REQ_BEGIN: begin
                     ic_in      = '0;
                     halted_in  = 1'b0;
                     pending_in = 1'b0;
                     rem_in     = '0;
                  end
                  REQ_STEP: begin
                     if (halted_ff) begin
                        kind_in = KIND_HALT;
                     end else if (pending_ff) begin
                        kind_in = KIND_WAIT;
                     end else if (ic_ff >= MEM_LIMIT) begin
                        halted_in = 1'b1;
                        kind_in   = KIND_ERR;
                     end else begin
                        st_req.re    = 1'b1;
                        st_req.raddr = ic_ff;
                        state_in     = ST_FETCH;
                     end
                  end
                  REQ_DATA: begin
                     if (!pending_ff || dptr_ff >= MEM_LIMIT) begin
                        kind_in = KIND_ERR;
                     end else begin
                        st_req.we    = 1'b1;
                        st_req.waddr = dptr_ff;
                        st_req.wdata = req_card_word;
                        dptr_in      = dptr_ff + 1'b1;
                        if (rem_ff > 1) begin
                           rem_in = rem_ff - 1'b1;
                        end else begin
                           rem_in     = '0;
                           pending_in = 1'b0;
                        end
                     end
                  end
                  default: begin
                     kind_in = KIND_ERR;
                  end
               endcase
            end
         end

         // instruction word is on the store output
         ST_FETCH: begin
            ic_in    = ic_ff + 1'b1;
            state_in = ST_RESULT;
            kind_in  = KIND_ACK;
            if ((c0 == CH_G || c0 == CH_P) && c1 == CH_D) begin
               if (!opnd_ok || !blk_ok) begin
                  halted_in = 1'b1;
                  kind_in   = KIND_ERR;
               end else if (c0 == CH_G) begin
                  pending_in = 1'b1;
                  dptr_in    = opnd;
                  rem_in     = BLK_CNT;
                  kind_in    = KIND_WAIT;
               end else begin
                  st_req.re    = 1'b1;
                  st_req.raddr = opnd;
                  pptr_in      = opnd + 1'b1;
                  pcnt_in      = '0;
                  state_in     = ST_PRINT;
               end
            end else if (c0 == CH_H) begin
               halted_in = 1'b1;
               kind_in   = KIND_HALT;
            end else if (c1 == CH_R && (c0 == CH_L || c0 == CH_S || c0 == CH_C)) begin
               if (!opnd_ok) begin
                  halted_in = 1'b1;
                  kind_in   = KIND_ERR;
               end else if (c0 == CH_S) begin
                  st_req.we    = 1'b1;
                  st_req.waddr = opnd;
                  st_req.wdata = greg_ff;
               end else begin
                  st_req.re    = 1'b1;
                  st_req.raddr = opnd;
                  state_in     = (c0 == CH_L) ? ST_LOAD : ST_CMP;
               end
            end else if (c0 == CH_B && c1 == CH_T && toggle_ff) begin
               if (!opnd_ok) begin
                  halted_in = 1'b1;
                  kind_in   = KIND_ERR;
               end else begin
                  ic_in = opnd;
               end
            end
         end

         ST_LOAD: begin
            greg_in  = st_rdata;
            state_in = ST_RESULT;
         end

         ST_CMP: begin
            toggle_in = (st_rdata == greg_ff);
            state_in  = ST_RESULT;
         end

         // one print word per free result slot
         ST_PRINT: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rkind_in = KIND_PRINT;
               rword_in = st_rdata;
               rmask_in = keep_mask_of(st_rdata);
               rlast_in = (pcnt_ff == BLK_LAST);
               rcnt_in  = ic_ff;
               rflag_in = toggle_ff;
               if (pcnt_ff == BLK_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  st_req.re    = 1'b1;
                  st_req.raddr = pptr_ff;
                  pptr_in      = pptr_ff + 1'b1;
                  pcnt_in      = pcnt_ff + 1'b1;
               end
            end
         end

         ST_RESULT: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rkind_in = kind_ff;
               rword_in = '0;
               rmask_in = '0;
               rlast_in = 1'b1;
               rcnt_in  = ic_ff;
               rflag_in = toggle_ff;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ic_ff      <= '0;
         greg_ff    <= SPACES;
         toggle_ff  <= 1'b0;
         lp_ff      <= '0;
         pending_ff <= 1'b0;
         dptr_ff    <= '0;
         rem_ff     <= '0;
         halted_ff  <= 1'b0;
         pptr_ff    <= '0;
         pcnt_ff    <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ic_ff      <= ic_in;
         greg_ff    <= greg_in;
         toggle_ff  <= toggle_in;
         lp_ff      <= lp_in;
         pending_ff <= pending_in;
         dptr_ff    <= dptr_in;
         rem_ff     <= rem_in;
         halted_ff  <= halted_in;
         pptr_ff    <= pptr_in;
         pcnt_ff    <= pcnt_in;
         rv_ff      <= rv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      rkind_ff <= rkind_in;
      rword_ff <= rword_in;
      rmask_ff <= rmask_in;
      rlast_ff <= rlast_in;
      rcnt_ff  <= rcnt_in;
      rflag_ff <= rflag_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_result_kind   = rkind_ff;
   assign rsp_print_word    = rword_ff;
   assign rsp_keep_mask     = rmask_ff;
   assign rsp_last_of_run   = rlast_ff;
   assign rsp_counter_value = rcnt_ff;
   assign rsp_compare_flag  = rflag_ff;

   // a halted machine never waits for data
   a_halt_no_pending: assert property (@(posedge clock) disable iff (reset)
      !(halted_ff && pending_ff))
      else $error("halted and data pending together");

   // a pending GD always has words left to take
   a_pending_rem: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (rem_ff != '0))
      else $error("data pending with no words left");

   // print count stays inside the block
   a_print_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRINT) |-> (pcnt_ff < BLK_CNT))
      else $error("print count past block");

   // only print words may leave a run open
   a_last_print: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rlast_ff) |-> (rkind_ff == KIND_PRINT))
      else $error("non-print result without last flag");

   // load pointer never passes the store size
   a_lp_bound: assert property (@(posedge clock) disable iff (reset)
      lp_ff <= MEM_LIMIT)
      else $error("load pointer past store");

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the card machine instruction executor: a planning
// copy of the machine shapes job decks, a live copy predicts every result
// word, and a monitor compares them field by field under random idling.
// ----------------------------------------------------------------------------
module tb;
   import cmie_pkg::*;

   localparam int MEMW        = MEM_WORDS_DEF;
   localparam int BLKW        = BLOCK_WORDS_DEF;
   localparam int TOTAL_ITEMS = 230;
   localparam int QUIET_LIMIT = 1000;
   localparam int TAIL_CYCLES = 30;

   // machine copies: one tracks the block, one runs ahead to plan the deck
   localparam int LIVE  = 0;
   localparam int AHEAD = 1;

   // request codes the block must reject
   localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd5;
   localparam logic [REQ_W-1:0] REQ_SPARE_C = 3'd7;

   typedef struct packed {
      logic [REQ_W-1:0]  kind;
      logic [WORD_W-1:0] word;
      logic              hold;
   } card_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] word;
      logic [MASK_W-1:0] mask;
      logic              last;
      logic [ADDR_W-1:0] pc;
      logic              flag;
   } outcome_type;

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [REQ_W-1:0]    req_type      = REQ_JOB;
   logic [WORD_W-1:0]   req_card_word = '0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [KIND_W-1:0]   rsp_result_kind;
   logic [WORD_W-1:0]   rsp_print_word;
   logic [MASK_W-1:0]   rsp_keep_mask;
   logic                rsp_last_of_run;
   logic [ADDR_W-1:0]   rsp_counter_value;
   logic                rsp_compare_flag;

   card_type    card_deck[$];
   outcome_type due_results[$];
   int          mismatches = 0;
   int          quiet_cycles = 0;
   bit          hold_next = 1'b0;

   // machine state, one set per copy
   logic [WORD_W-1:0] store_m [2][MEMW];
   logic [WORD_W-1:0] acc_m [2];
   int                pc_m [2];
   int                load_m [2];
   int                dptr_m [2];
   int                dleft_m [2];
   bit                flag_m [2];
   bit                wait_m [2];
   bit                stop_m [2];

   card_machine_instruction_executor_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_card_word     (req_card_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_print_word    (rsp_print_word),
      .rsp_keep_mask     (rsp_keep_mask),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_counter_value (rsp_counter_value),
      .rsp_compare_flag  (rsp_compare_flag)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // machine model
   // ------------------------------------------------------------------------
   function automatic void machine_clear(int s);
      for (int i = 0; i < MEMW; i++) store_m[s][i] = SPACES;
      acc_m[s]   = SPACES;
      pc_m[s]    = 0;
      load_m[s]  = 0;
      dptr_m[s]  = 0;
      dleft_m[s] = 0;
      flag_m[s]  = 1'b0;
      wait_m[s]  = 1'b0;
      stop_m[s]  = 1'b0;
   endfunction

   // only the live copy records results; counter and toggle as they stand now
   function automatic void note(int s, logic [KIND_W-1:0] kind, logic [WORD_W-1:0] w,
                                bit last);
      outcome_type r;
      r.kind = kind;
      r.word = w;
      r.mask = '0;
      if (kind == KIND_PRINT)
         r.mask = {w[31:24] != CH_SPACE, w[23:16] != CH_SPACE,
                   w[15:8] != CH_SPACE, w[7:0] != CH_SPACE};
      r.last = last;
      r.pc   = pc_m[s][ADDR_W-1:0];
      r.flag = flag_m[s];
      if (s == LIVE) due_results.insert(due_results.size(), r);
   endfunction

   // two decimal digits in the last two characters, below the store size
   function automatic bit card_addr(logic [WORD_W-1:0] w, output int a);
      logic [7:0] t, u;
      t = w[15:8];
      u = w[7:0];
      a = 0;
      if (t < CH_ZERO || t > CH_NINE || u < CH_ZERO || u > CH_NINE) return 1'b0;
      a = (int'(t) - int'(CH_ZERO)) * 10 + (int'(u) - int'(CH_ZERO));
      return a < MEMW;
   endfunction

   function automatic void machine_step(int s);
      logic [WORD_W-1:0] ir;
      logic [7:0]        op, md;
      int                a;
      bit                ok;
      if (stop_m[s]) begin
         note(s, KIND_HALT, '0, 1'b1);
         return;
      end
      if (wait_m[s]) begin
         note(s, KIND_WAIT, '0, 1'b1);
         return;
      end
      if (pc_m[s] >= MEMW) begin
         stop_m[s] = 1'b1;
         note(s, KIND_ERR, '0, 1'b1);
         return;
      end
      ir = store_m[s][pc_m[s]];
      pc_m[s]++;
      op = ir[31:24];
      md = ir[23:16];
      ok = card_addr(ir, a);
      // block transfers
      if ((op == CH_G || op == CH_P) && md == CH_D) begin
         if (!ok || a + BLKW > MEMW) begin
            stop_m[s] = 1'b1;
            note(s, KIND_ERR, '0, 1'b1);
            return;
         end
         if (op == CH_G) begin
            wait_m[s]  = 1'b1;
            dptr_m[s]  = a;
            dleft_m[s] = BLKW;
            note(s, KIND_WAIT, '0, 1'b1);
            return;
         end
         for (int i = 0; i < BLKW; i++) note(s, KIND_PRINT, store_m[s][a + i], i == BLKW - 1);
         return;
      end
      if (op == CH_H) begin
         stop_m[s] = 1'b1;
         note(s, KIND_HALT, '0, 1'b1);
         return;
      end
      // register moves and compare
      if (md == CH_R && (op == CH_L || op == CH_S || op == CH_C)) begin
         if (!ok) begin
            stop_m[s] = 1'b1;
            note(s, KIND_ERR, '0, 1'b1);
            return;
         end
         if (op == CH_L) acc_m[s] = store_m[s][a];
         else if (op == CH_S) store_m[s][a] = acc_m[s];
         else flag_m[s] = (store_m[s][a] == acc_m[s]);
      end else if (op == CH_B && md == CH_T && flag_m[s]) begin
         // address only matters when the branch is taken
         if (!ok) begin
            stop_m[s] = 1'b1;
            note(s, KIND_ERR, '0, 1'b1);
            return;
         end
         pc_m[s] = a;
      end
      note(s, KIND_ACK, '0, 1'b1);
   endfunction

   function automatic void machine_take(int s, logic [REQ_W-1:0] t, logic [WORD_W-1:0] w);
      case (t)
         REQ_JOB: machine_clear(s);
         REQ_PROG: begin
            // a full store drops the word
            if (load_m[s] < MEMW) begin
               store_m[s][load_m[s]] = w;
               load_m[s]++;
            end
         end
         REQ_BEGIN: begin
            pc_m[s]    = 0;
            stop_m[s]  = 1'b0;
            wait_m[s]  = 1'b0;
            dleft_m[s] = 0;
         end
         REQ_STEP: begin
            machine_step(s);
            return;
         end
         REQ_DATA: begin
            if (!wait_m[s] || dptr_m[s] >= MEMW) begin
               note(s, KIND_ERR, '0, 1'b1);
               return;
            end
            store_m[s][dptr_m[s]] = w;
            dptr_m[s]++;
            if (dleft_m[s] > 0) dleft_m[s]--;
            if (dleft_m[s] == 0) wait_m[s] = 1'b0;
         end
         default: begin
            note(s, KIND_ERR, '0, 1'b1);
            return;
         end
      endcase
      note(s, KIND_ACK, '0, 1'b1);
   endfunction

   // ------------------------------------------------------------------------
   // deck building
   // ------------------------------------------------------------------------
   function automatic logic [WORD_W-1:0] instr_word(logic [7:0] op, logic [7:0] md, int a);
      return {op, md, CH_ZERO + 8'(a / 10), CH_ZERO + 8'(a % 10)};
   endfunction

   function automatic logic [WORD_W-1:0] random_instr();
      logic [7:0] op, md, hi, lo;
      int         a;
      a  = $urandom_range(0, MEMW - 1);
      md = CH_SPACE;
      case ($urandom_range(0, 15))
         0, 1:   begin op = CH_L; md = CH_R; end
         2, 3:   begin op = CH_S; md = CH_R; end
         4, 5:   begin op = CH_C; md = CH_R; end
         6, 7:   begin op = CH_B; md = CH_T; end
         8:      begin op = CH_G; md = CH_D; a = $urandom_range(0, MEMW - 7); end
         9, 10:  begin op = CH_P; md = CH_D; a = $urandom_range(0, MEMW - 7); end
         11:     op = CH_H;
         // near miss, not an instruction
         12:     begin op = CH_B; md = CH_R; end
         default: begin op = 8'($urandom); md = 8'($urandom); end
      endcase
      hi = CH_ZERO + 8'(a / 10);
      lo = CH_ZERO + 8'(a % 10);
      // broken address digit now and then
      if ($urandom_range(0, 11) == 0) begin
         if ($urandom_range(0, 1) == 1) hi = 8'($urandom);
         else lo = 8'($urandom);
      end
      return {op, md, hi, lo};
   endfunction

   // random content with plenty of spaces so print masks vary
   function automatic logic [WORD_W-1:0] random_card();
      logic [WORD_W-1:0] w;
      w = $urandom;
      for (int i = 0; i < 4; i++)
         if ($urandom_range(0, 2) == 0) w[8*i +: 8] = CH_SPACE;
      if ($urandom_range(0, 5) == 0) w = random_instr();
      return w;
   endfunction

   function automatic void plan_item(logic [REQ_W-1:0] t, logic [WORD_W-1:0] w);
      card_type c;
      c.kind = t;
      c.word = w;
      c.hold = hold_next;
      hold_next = 1'b0;
      card_deck.insert(card_deck.size(), c);
      machine_take(AHEAD, t, w);
   endfunction

   // begin execute and step through, feeding data blocks as GD asks
   function automatic void plan_run(int budget);
      int cut;
      plan_item(REQ_BEGIN, $urandom);
      for (int k = 0; k < budget && !stop_m[AHEAD]; k++) begin
         plan_item(REQ_STEP, $urandom);
         if (wait_m[AHEAD]) begin
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, BLKW - 1) : BLKW;
            for (int j = 0; j < BLKW; j++) begin
               if (j == cut) plan_item(REQ_STEP, $urandom);
               plan_item(REQ_DATA, random_card());
            end
            if ($urandom_range(0, 7) == 0) plan_item(REQ_DATA, random_card());
         end
         // noise of any request type
         if ($urandom_range(0, 19) == 0) plan_item(REQ_W'($urandom_range(0, 7)), $urandom);
      end
      if ($urandom_range(0, 2) == 0) plan_item(REQ_STEP, $urandom);
   endfunction

   initial begin
      int n;
      machine_clear(AHEAD);

      // rejected requests and a step straight out of reset
      plan_item(REQ_SPARE_C, 32'hFFFF_FFFF);
      plan_item(REQ_SPARE_A, 32'h0000_0000);
      plan_item(REQ_DATA, $urandom);
      plan_item(REQ_STEP, $urandom);
      // load, store, compare, taken branch, print, bad address, halted
      plan_item(REQ_JOB, $urandom);
      plan_item(REQ_PROG, instr_word(CH_L, CH_R, 7));
      plan_item(REQ_PROG, instr_word(CH_S, CH_R, 8));
      plan_item(REQ_PROG, instr_word(CH_C, CH_R, 8));
      plan_item(REQ_PROG, instr_word(CH_B, CH_T, 5));
      plan_item(REQ_PROG, {CH_H, CH_SPACE, CH_SPACE, CH_SPACE});
      plan_item(REQ_PROG, instr_word(CH_P, CH_D, 0));
      plan_item(REQ_PROG, {CH_G, CH_D, CH_NINE, CH_C});
      plan_item(REQ_PROG, 32'hFFFF_FFFF);
      plan_item(REQ_BEGIN, $urandom);
      repeat (7) plan_item(REQ_STEP, $urandom);
      plan_item(REQ_BEGIN, $urandom);
      plan_item(REQ_STEP, $urandom);
      plan_item(REQ_PROG, 32'h0000_0000);
      plan_item(REQ_STEP, $urandom);

      // full store: branch near the end and run off the end of memory
      hold_next = 1'b1;
      plan_item(REQ_JOB, $urandom);
      for (int i = 0; i < MEMW + 2; i++) begin
         if (i == 0) plan_item(REQ_PROG, instr_word(CH_C, CH_R, MEMW - 3));
         else if (i == 1) plan_item(REQ_PROG, instr_word(CH_B, CH_T, MEMW - 2));
         else if (i == MEMW - 3) plan_item(REQ_PROG, SPACES);
         else if (i >= MEMW - 2) plan_item(REQ_PROG, {CH_T, CH_T, CH_ZERO, CH_ZERO});
         else plan_item(REQ_PROG, random_instr());
      end
      plan_run(8);

      // random jobs, the first one after a full drain
      hold_next = 1'b1;
      while (card_deck.size() < TOTAL_ITEMS) begin
         n = $urandom_range(3, 14);
         if ($urandom_range(0, 3) != 0) plan_item(REQ_JOB, $urandom);
         for (int i = 0; i < n; i++) plan_item(REQ_PROG, random_instr());
         plan_run(n + $urandom_range(2, 10));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (card_deck.size() != 0 || req_valid || due_results.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   int tx_gap   = 0;
   bit tx_burst = 1'b0;
   bit tx_next;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap = 0;
         machine_clear(LIVE);
      end else begin
         tx_next = req_valid;
         // word taken: predict its results, draw the gap to the next one
         if (req_valid && !req_stall) begin
            machine_take(LIVE, req_type, req_card_word);
            tx_next = 1'b0;
            if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
            tx_gap = tx_burst ? 0 : $urandom_range(0, 17);
         end
         if (!tx_next) begin
            if (tx_gap > 0) tx_gap--;
            else if (card_deck.size() != 0 &&
                     !(card_deck[0].hold && due_results.size() != 0)) begin
               req_type      <= card_deck[0].kind;
               req_card_word <= card_deck[0].word;
               void'(card_deck.pop_front());
               tx_next = 1'b1;
            end
         end
         req_valid <= tx_next;
      end
   end

   // ------------------------------------------------------------------------
   // result monitor
   // ------------------------------------------------------------------------
   int          rx_hold  = 0;
   bit          rx_burst = 1'b0;
   outcome_type rx_want;

   task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                  logic [WORD_W-1:0] want);
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               report_mismatch("unexpected word, kind", WORD_W'(rsp_result_kind), '0);
            end else begin
               rx_want = due_results.pop_front();
               if (rsp_result_kind != rx_want.kind)
                  report_mismatch("result_kind", WORD_W'(rsp_result_kind),
                                  WORD_W'(rx_want.kind));
               if (rsp_print_word != rx_want.word)
                  report_mismatch("print_word", rsp_print_word, rx_want.word);
               if (rsp_keep_mask != rx_want.mask)
                  report_mismatch("keep_mask", WORD_W'(rsp_keep_mask),
                                  WORD_W'(rx_want.mask));
               if (rsp_last_of_run != rx_want.last)
                  report_mismatch("last_of_run", WORD_W'(rsp_last_of_run),
                                  WORD_W'(rx_want.last));
               if (rsp_counter_value != rx_want.pc)
                  report_mismatch("counter_value", WORD_W'(rsp_counter_value),
                                  WORD_W'(rx_want.pc));
               if (rsp_compare_flag != rx_want.flag)
                  report_mismatch("compare_flag", WORD_W'(rsp_compare_flag),
                                  WORD_W'(rx_want.flag));
            end
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
            rx_hold = rx_burst ? 0 : $urandom_range(0, 17);
         end else if (rx_hold > 0) begin
            rx_hold--;
         end
         rsp_stall <= (rx_hold != 0);
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
